// ----- rtl/error_ellipse_semi_axis_top_macros.svh -----
// Assertion macros for the error ellipse semi-axis block.
`ifndef ERROR_ELLIPSE_SEMI_AXIS_TOP_MACROS_SVH
`define ERROR_ELLIPSE_SEMI_AXIS_TOP_MACROS_SVH

// Checked only while out of reset.
`define EESA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("eesa assertion failed");

// Checked at every edge, reset included.
`define EESA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("eesa assertion failed");

`endif

// ----- rtl/eesa_pkg.sv -----
//------------------------------------------------------------------------------
// eesa_pkg
// Shared constants and types of the error ellipse semi-axis block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package eesa_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int OUT_W             = 24;

    typedef enum logic [1:0] {
        MODE_X_AXIS = 2'd0,
        MODE_Y_AXIS = 2'd1,
        MODE_MAJOR  = 2'd2,
        MODE_MINOR  = 2'd3
    } mode_t;

endpackage

// ----- rtl/eesa_front.sv -----
//------------------------------------------------------------------------------
// eesa_front
// Three-stage front end: magnitudes, products, PSD test and root radicand.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module eesa_front #(
    parameter int VALUE_WIDTH = eesa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [VALUE_WIDTH-1:0]     var_x,
    input  logic [VALUE_WIDTH-1:0]     var_y,
    input  logic [VALUE_WIDTH-1:0]     cov_xy,
    input  logic [1:0]                 mode,
    output logic                       out_valid,
    output logic [2*VALUE_WIDTH+1:0]   radicand,
    output logic [VALUE_WIDTH:0]       sum,
    output logic                       use_major,
    output logic                       npsd
);

    localparam int W = VALUE_WIDTH;

    // stage 1
    logic           v1_reg;
    logic [W-1:0]   a1_reg, b1_reg, c1_reg, d1_reg;
    logic [W:0]     s1_reg;
    logic           m1_reg;
    logic [W-1:0]   cmag_next, diff_next;
    logic           major_next;
    eesa_pkg::mode_t mode_sel;

    // stage 2
    logic           v2_reg;
    logic [2*W-1:0] pcc2_reg, pab2_reg, pdd2_reg;
    logic [W:0]     s2_reg;
    logic           m2_reg;

    // stage 3
    logic           v3_reg;
    logic [2*W+1:0] rad3_reg;
    logic [W:0]     s3_reg;
    logic           m3_reg, n3_reg;

    always_comb begin
        mode_sel  = eesa_pkg::mode_t'(mode);
        cmag_next = cov_xy[W-1] ? (~cov_xy + W'(1)) : cov_xy;
        diff_next = (var_x > var_y) ? (var_x - var_y) : (var_y - var_x);
        case (mode_sel)
            eesa_pkg::MODE_X_AXIS: major_next = var_x > var_y;
            eesa_pkg::MODE_Y_AXIS: major_next = var_y > var_x;
            eesa_pkg::MODE_MAJOR:  major_next = 1'b1;
            eesa_pkg::MODE_MINOR:  major_next = 1'b0;
            default:               major_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= var_x;
            b1_reg   <= var_y;
            c1_reg   <= cmag_next;
            d1_reg   <= diff_next;
            s1_reg   <= {1'b0, var_x} + {1'b0, var_y};
            m1_reg   <= major_next;

            pcc2_reg <= c1_reg * c1_reg;
            pab2_reg <= a1_reg * b1_reg;
            pdd2_reg <= d1_reg * d1_reg;
            s2_reg   <= s1_reg;
            m2_reg   <= m1_reg;

            rad3_reg <= {2'b00, pdd2_reg} + {pcc2_reg, 2'b00};
            n3_reg   <= pcc2_reg > pab2_reg;
            s3_reg   <= s2_reg;
            m3_reg   <= m2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign radicand  = rad3_reg;
    assign sum       = s3_reg;
    assign use_major = m3_reg;
    assign npsd      = n3_reg;

endmodule

// ----- rtl/eesa_sqrt.sv -----
//------------------------------------------------------------------------------
// eesa_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module eesa_sqrt #(
    parameter int IN_W   = 66,
    parameter int SIDE_W = 1,
    localparam int ROOT_W = (IN_W + 1) / 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int R  = ROOT_W;
    localparam int NW = 2 * R;
    localparam int RW = R + 3;

    logic              vld_reg  [0:R-1];
    logic [RW-1:0]     rem_reg  [0:R-1];
    logic [R-1:0]      root_reg [0:R-1];
    logic [NW-1:0]     rad_reg  [0:R-1];
    logic [SIDE_W-1:0] side_reg [0:R-1];

    for (genvar k = 0; k < R; k++) begin : g_stage
        logic              cur_vld;
        logic [RW-1:0]     cur_rem;
        logic [R-1:0]      cur_root;
        logic [NW-1:0]     cur_rad;
        logic [SIDE_W-1:0] cur_side;
        logic [RW-1:0]     shifted, trial;
        logic [RW-1:0]     rem_next;
        logic [R-1:0]      root_next;

        if (k == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_rem  = '0;
            assign cur_root = '0;
            assign cur_rad  = NW'(radicand);
            assign cur_side = in_side;
        end else begin : g_next
            assign cur_vld  = vld_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_root = root_reg[k-1];
            assign cur_rad  = rad_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        always_comb begin
            shifted = {cur_rem[RW-3:0], cur_rad[NW-1:NW-2]};
            trial   = RW'({cur_root, 2'b01});
            if (shifted >= trial) begin
                rem_next  = shifted - trial;
                root_next = {cur_root[R-2:0], 1'b1};
            end else begin
                rem_next  = shifted;
                root_next = {cur_root[R-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {cur_rad[NW-3:0], 2'b00};
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_valid = vld_reg[R-1];
    assign root      = root_reg[R-1];
    assign out_side  = side_reg[R-1];

endmodule

// ----- rtl/error_ellipse_semi_axis_top.sv -----
//------------------------------------------------------------------------------
// error_ellipse_semi_axis_top
// Semi-axis length of the error ellipse of a 2x2 covariance matrix.
//------------------------------------------------------------------------------
// Takes one transaction per cycle unless stalled and returns one result per
// transaction, in order. The pipeline runs a front end, a bit-per-stage square
// root, a select register, a second bit-per-stage square root and an output
// register. The whole pipeline holds while a result waits on m_ready.
`timescale 1ns / 1ps

module error_ellipse_semi_axis_top #(
    parameter int FRACTION_BITS = eesa_pkg::FRACTION_BITS_DEF,
    parameter int VALUE_WIDTH   = eesa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [VALUE_WIDTH-1:0]        s_variance_x,
    input  logic [VALUE_WIDTH-1:0]        s_variance_y,
    input  logic signed [VALUE_WIDTH-1:0] s_covariance_xy,
    input  logic [1:0]                    s_mode,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [eesa_pkg::OUT_W-1:0]    m_axis_length,
    output logic                          m_not_semidefinite
);

    localparam int W      = VALUE_WIDTH;
    localparam int F      = FRACTION_BITS;
    localparam int OW     = eesa_pkg::OUT_W;
    localparam int RAD1_W = 2 * W + 2;
    localparam int D_W    = (RAD1_W + 1) / 2;
    localparam int SIDE_W = W + 3;
    localparam int E_W    = W + 2;
    localparam int RAD2_W = E_W + F - 1;
    localparam int LEN_W  = (RAD2_W + 1) / 2;

    logic              en;
    logic              f_valid, f_major, f_npsd;
    logic [RAD1_W-1:0] f_rad;
    logic [W:0]        f_sum;

    logic              d_valid;
    logic [D_W-1:0]    d_root;
    logic [SIDE_W-1:0] d_side;
    logic [W:0]        d_sum;
    logic [E_W-1:0]    e_maj, e_min;

    logic              e_valid_reg;
    logic [RAD2_W-1:0] e_rad_reg;
    logic              e_npsd_reg;

    logic              l_valid;
    logic [LEN_W-1:0]  l_root;
    logic              l_npsd;
    logic [LEN_W+OW-1:0] l_ext;

    logic              m_valid_reg, m_npsd_reg;
    logic [OW-1:0]     m_len_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    eesa_front #(
        .VALUE_WIDTH (W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .var_x     (s_variance_x),
        .var_y     (s_variance_y),
        .cov_xy    (s_covariance_xy),
        .mode      (s_mode),
        .out_valid (f_valid),
        .radicand  (f_rad),
        .sum       (f_sum),
        .use_major (f_major),
        .npsd      (f_npsd)
    );

    eesa_sqrt #(
        .IN_W   (RAD1_W),
        .SIDE_W (SIDE_W)
    ) u_sqrt_d (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .radicand  (f_rad),
        .in_side   ({f_npsd, f_major, f_sum}),
        .out_valid (d_valid),
        .root      (d_root),
        .out_side  (d_side)
    );

    assign d_sum = d_side[W:0];
    assign e_maj = E_W'(d_sum) + E_W'(d_root);
    assign e_min = E_W'(d_sum) - E_W'(d_root);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_rad_reg  <= {(d_side[W+1] ? e_maj : e_min), {(F-1){1'b0}}};
            e_npsd_reg <= d_side[W+2];
        end
    end

    eesa_sqrt #(
        .IN_W   (RAD2_W),
        .SIDE_W (1)
    ) u_sqrt_len (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e_valid_reg),
        .radicand  (e_rad_reg),
        .in_side   (e_npsd_reg),
        .out_valid (l_valid),
        .root      (l_root),
        .out_side  (l_npsd)
    );

    assign l_ext = (LEN_W + OW)'(l_root);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= l_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_npsd_reg <= l_npsd;
            if (l_npsd) begin
                m_len_reg <= '0;
            end else if (|l_ext[LEN_W+OW-1:OW]) begin
                m_len_reg <= '1;
            end else begin
                m_len_reg <= l_ext[OW-1:0];
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_axis_length      = m_len_reg;
    assign m_not_semidefinite = m_npsd_reg;

endmodule

// ----- rtl/eesa_checker.sv -----
//------------------------------------------------------------------------------
// eesa_checker
// Port-level checks of the error ellipse semi-axis block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "error_ellipse_semi_axis_top_macros.svh"

module eesa_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [eesa_pkg::OUT_W-1:0] m_axis_length,
    input logic                       m_not_semidefinite
);

    `EESA_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)
    `EESA_ASSERT(a_ready_rule, aclk, aresetn, s_ready == (!m_valid || m_ready))
    `EESA_ASSERT(a_npsd_zero, aclk, aresetn, (m_valid && m_not_semidefinite) |-> (m_axis_length == '0))
    `EESA_ASSERT(a_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid)

endmodule

bind error_ellipse_semi_axis_top eesa_checker u_eesa_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_axis_length      (m_axis_length),
    .m_not_semidefinite (m_not_semidefinite)
);

// ----- tb/tb_error_ellipse_semi_axis_top.sv -----
//------------------------------------------------------------------------------
// tb_error_ellipse_semi_axis_top
// Self-checking bench for the error ellipse semi-axis block.
//------------------------------------------------------------------------------
// A queued driver sends covariance sets with random idle bursts. Each accepted
// transaction is run through an exact wide-integer model of the eigenvalue
// and square-root math. A monitor under random backpressure compares every
// result in order.
`timescale 1ns / 1ps

module tb_error_ellipse_semi_axis_top;

    localparam int FB = 16;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0]     vx;
        logic [31:0]     vy;
        logic [31:0]     cov;
        eesa_pkg::mode_t mode;
    } cov_set_t;

    typedef struct packed {
        logic [23:0] len;
        logic        nsd;
    } axis_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_variance_x = '0;
    logic [31:0] s_variance_y = '0;
    logic signed [31:0] s_covariance_xy = '0;
    logic [1:0]  s_mode = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_axis_length;
    logic        m_not_semidefinite;

    cov_set_t pending_sets[$];
    axis_t    expected_axes[$];
    bit       stim_done = 0;
    bit       quiet = 0;
    int       errors = 0;
    int       results_seen = 0;
    int       flagged_seen = 0;
    int       s_idle = 0;
    int       m_idle = 0;
    longint   cycles = 0;

    error_ellipse_semi_axis_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_variance_x(s_variance_x), .s_variance_y(s_variance_y),
        .s_covariance_xy(s_covariance_xy), .s_mode(s_mode),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_axis_length(m_axis_length), .m_not_semidefinite(m_not_semidefinite)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [63:0] isqrt128(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (128'(t) * 128'(t) <= n) r = t;
        end
        return r;
    endfunction

    function automatic axis_t semi_axis(cov_set_t c);
        axis_t       res;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] cm;
        logic [63:0] d;
        logic [63:0] dt;
        logic [63:0] sel;
        logic [63:0] len;
        a = 64'(c.vx);
        b = 64'(c.vy);
        cm = c.cov[31] ? (64'h1_0000_0000 - 64'(c.cov)) : 64'(c.cov);
        if (128'(cm) * 128'(cm) > 128'(a) * 128'(b)) begin
            res.len = '0;
            res.nsd = 1'b1;
            return res;
        end
        d = (a > b) ? a - b : b - a;
        dt = isqrt128(128'(d) * 128'(d) + 128'(cm) * 128'(cm) * 128'd4);
        case (c.mode)
            eesa_pkg::MODE_X_AXIS: sel = (a > b) ? a + b + dt : a + b - dt;
            eesa_pkg::MODE_Y_AXIS: sel = (b > a) ? a + b + dt : a + b - dt;
            eesa_pkg::MODE_MAJOR:  sel = a + b + dt;
            default:               sel = a + b - dt;
        endcase
        len = isqrt128(128'(sel) << (FB - 1));
        res.len = (len > 64'hFF_FFFF) ? 24'hFF_FFFF : len[23:0];
        res.nsd = 1'b0;
        return res;
    endfunction

    function automatic logic [31:0] rand_var();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 255);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            2: return 32'($urandom_range(0, 16)) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_set(logic [31:0] vx, logic [31:0] vy, logic [31:0] cv,
                            eesa_pkg::mode_t m);
        cov_set_t c;
        c.vx = vx;
        c.vy = vy;
        c.cov = cv;
        c.mode = m;
        pending_sets.push_back(c);
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_axes.push_back(semi_axis({s_variance_x, s_variance_y,
                                                   s_covariance_xy,
                                                   eesa_pkg::mode_t'(s_mode)}));
            end
            if (!s_valid || s_ready) begin
                if (s_idle > 0) begin
                    s_idle <= s_idle - 1;
                    s_valid <= 1'b0;
                end else if (pending_sets.size() > 0) begin
                    cov_set_t c;
                    c = pending_sets.pop_front();
                    s_valid <= 1'b1;
                    s_variance_x <= c.vx;
                    s_variance_y <= c.vy;
                    s_covariance_xy <= c.cov;
                    s_mode <= c.mode;
                    if (!quiet && $urandom_range(0, 9) == 0) s_idle <= $urandom_range(1, 16);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_not_semidefinite) flagged_seen++;
                if (expected_axes.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected transaction len=%h nsd=%b",
                                               m_axis_length, m_not_semidefinite);
                end else begin
                    axis_t e;
                    e = expected_axes.pop_front();
                    if (e.len !== m_axis_length || e.nsd !== m_not_semidefinite) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp len=%h nsd=%b, got len=%h nsd=%b",
                                     e.len, e.nsd, m_axis_length, m_not_semidefinite);
                    end
                end
            end
            if (m_idle > 0) begin
                m_idle <= m_idle - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) m_idle <= $urandom_range(1, 16);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** error_ellipse_semi_axis_top: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] cv;
        for (int m = 0; m < 4; m++) begin
            push_set(32'h0, 32'h0, 32'h0, eesa_pkg::mode_t'(m));
            push_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, eesa_pkg::mode_t'(m));
            push_set(32'h0003_0000, 32'h0001_0000, 32'hFFFF_8000, eesa_pkg::mode_t'(m));
            push_set(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, eesa_pkg::mode_t'(m));
        end
        push_set(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, eesa_pkg::MODE_MAJOR);
        push_set(32'h0001_0000, 32'h0004_0000, 32'h0002_0001, eesa_pkg::MODE_MINOR);
        push_set(32'h0001_0000, 32'h0004_0000, 32'h0002_0000, eesa_pkg::MODE_MINOR);
        push_set(32'hFFFF_FFFF, 32'h0, 32'h0, eesa_pkg::MODE_X_AXIS);
        push_set(32'h0, 32'hFFFF_FFFF, 32'h0, eesa_pkg::MODE_Y_AXIS);
        push_set(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, eesa_pkg::MODE_MAJOR);
        for (int i = 0; i < 450; i++) begin
            a = rand_var();
            b = rand_var();
            case ($urandom_range(0, 3))
                0: cv = $urandom;
                1: cv = 32'(isqrt128(128'(a) * 128'(b)));
                default: cv = $urandom_range(0, 32'(isqrt128(128'(a) * 128'(b))));
            endcase
            if ($urandom_range(0, 1)) cv = -cv;
            push_set(a, b, cv, eesa_pkg::mode_t'($urandom_range(0, 3)));
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_sets.size() < 70);
        quiet = 1;
        wait (pending_sets.size() == 0);
        @(posedge aclk);
        while (s_valid) @(posedge aclk);
        while (expected_axes.size() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
        $display("checked %0d results, %0d flagged not semidefinite,", results_seen, flagged_seen);
        $display("all four modes, extreme variances and tie cases included");
        if (errors == 0) begin
            $display("** error_ellipse_semi_axis_top: PASSED **");
        end else begin
            $display("%0d mismatches", errors);
            $display("** error_ellipse_semi_axis_top: FAILED **");
        end
        $finish;
    end
endmodule
